>>> design/alt_pkg.sv
// Shared types, constants and token kind codes for the assembler line tokenizer.
// Used by all design files, the port checker and the testbench; no dependencies.
`default_nettype none

package alt_pkg;

  // Line geometry: columns and lengths saturate at LINE_MAX-1
  localparam int unsigned LINE_MAX = 4096;
  localparam int unsigned COL_W    = 12;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(LINE_MAX - 1);

  // Queue depths (powers of two)
  localparam int unsigned FE_DEPTH = 4;
  localparam int unsigned FE_AW    = $clog2(FE_DEPTH);
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  // Token kinds
  localparam logic [3:0] KIND_OP     = 4'd0;
  localparam logic [3:0] KIND_SQUOTE = 4'd1;
  localparam logic [3:0] KIND_DQUOTE = 4'd2;
  localparam logic [3:0] KIND_DOLLAR = 4'd3;
  localparam logic [3:0] KIND_AMP    = 4'd4;
  localparam logic [3:0] KIND_BIN    = 4'd5;
  localparam logic [3:0] KIND_NAME   = 4'd6;
  localparam logic [3:0] KIND_STRAY  = 4'd7;
  localparam logic [3:0] KIND_EOL    = 4'd8;

  // Character classes of one byte
  typedef struct packed {
    logic zero;
    logic space;
    logic semi;
    logic op;
    logic squote;
    logic dquote;
    logic dollar;
    logic amp;
    logic pct;
    logic name;
    logic hex;
    logic bin;
  } byte_info_t;

  // Classified byte handed from front to back
  typedef struct packed {
    byte_info_t       info;
    logic [COL_W-1:0] col;
  } fe_item_t;

  // Front-to-back channel
  typedef struct packed {
    logic     valid;
    fe_item_t item;
  } fe_chan_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [COL_W-1:0] start;
    logic [COL_W-1:0] len;
  } token_t;

  // All results caused by one byte: one or two tokens
  typedef struct packed {
    logic   two;
    token_t r0;
    token_t r1;
  } res_entry_t;

endpackage

`default_nettype wire

>>> design/alt_front.sv
// Front end: accepts bytes, tracks the column and classifies each byte.
// Holds classified bytes in a short queue for alt_back. Depends on alt_pkg.
`default_nettype none

module alt_front import alt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] character_i,
  input  wire logic       push_i,
  output logic            full_o,
  output fe_chan_t        fe_o,
  input  wire logic       fe_pop_i
);

  fe_item_t         fe_mem_q [FE_DEPTH];
  logic [FE_AW-1:0] wr_q, rd_q;
  logic [FE_AW:0]   cnt_q;
  logic [COL_W-1:0] col_q;
  logic             acc;
  byte_info_t       info;
  logic             is_ident;

  assign full_o = (cnt_q == (FE_AW+1)'(FE_DEPTH));
  assign acc    = push_i & ~full_o;

  always_comb begin
    is_ident = ((character_i >= 8'h30) && (character_i <= 8'h39)) ||
               ((character_i >= 8'h41) && (character_i <= 8'h5A)) ||
               ((character_i >= 8'h61) && (character_i <= 8'h7A)) ||
               (character_i == 8'h5F);
    info        = '0;
    info.zero   = (character_i == 8'h00);
    info.space  = (character_i >= 8'h01) && (character_i <= 8'h20);
    info.semi   = (character_i == 8'h3B);
    info.squote = (character_i == 8'h27);
    info.dquote = (character_i == 8'h22);
    info.dollar = (character_i == 8'h24);
    info.amp    = (character_i == 8'h26);
    info.pct    = (character_i == 8'h25);
    info.name   = is_ident || (character_i == 8'h2E);
    info.hex    = ((character_i >= 8'h30) && (character_i <= 8'h39)) ||
                  ((character_i >= 8'h41) && (character_i <= 8'h46)) ||
                  ((character_i >= 8'h61) && (character_i <= 8'h66));
    info.bin    = (character_i == 8'h30) || (character_i == 8'h31);
    // ! ~ + - * / \ ( ) , = { } < >
    unique case (character_i) inside
      8'h21, 8'h7E, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5C, 8'h28, 8'h29,
      8'h2C, 8'h3D, 8'h7B, 8'h7D, 8'h3C, 8'h3E: info.op = 1'b1;
      default: info.op = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      fe_mem_q[wr_q] <= '{info: info, col: col_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      col_q <= '0;
    end else begin
      if (acc) begin
        wr_q <= wr_q + 1'b1;
        // restart at column 0 after the line end, hold at the cap
        if (info.zero) begin
          col_q <= '0;
        end else if (col_q != COL_MAX) begin
          col_q <= col_q + 1'b1;
        end
      end
      if (fe_pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({acc, fe_pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assign fe_o.valid = (cnt_q != '0);
  assign fe_o.item  = fe_mem_q[rd_q];

endmodule

`default_nettype wire

>>> design/alt_back.sv
// Back end: scanner state machine, one classified byte per cycle unless the result queue is full.
// Emits an entry of one or two tokens per byte that closes tokens. Depends on alt_pkg.
`default_nettype none

module alt_back import alt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire fe_chan_t fe_i,
  output logic          fe_pop_o,
  output logic          res_push_o,
  output res_entry_t    res_o,
  input  wire logic     res_full_i
);

  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_COMMENT = 4'd1;
  localparam logic [3:0] M_QOPEN   = 4'd2;
  localparam logic [3:0] M_QTWO    = 4'd3;
  localparam logic [3:0] M_STRING  = 4'd4;
  localparam logic [3:0] M_DOLLAR  = 4'd5;
  localparam logic [3:0] M_DHEX    = 4'd6;
  localparam logic [3:0] M_AHEX    = 4'd7;
  localparam logic [3:0] M_BIN     = 4'd8;
  localparam logic [3:0] M_NAME    = 4'd9;

  logic [3:0]       mode_q, mode_d;
  logic             qd_q, qd_d;
  logic [COL_W-1:0] start_q, start_d;

  byte_info_t       b;
  logic [COL_W-1:0] col, st, len_ex, len_in;
  logic [COL_W:0]   len_wide;
  logic             step, again, do_str, qhit, cont, e0_v, e1_v;
  logic [3:0]       str_kind, run_kind;
  token_t           e0, e1;

  assign step     = fe_i.valid & ~res_full_i;
  assign fe_pop_o = step;

  always_comb begin
    b        = fe_i.item.info;
    col      = fe_i.item.col;
    st       = (start_q > col) ? col : start_q;
    len_ex   = col - st;
    len_wide = {1'b0, col} + (COL_W+1)'(1) - {1'b0, st};
    len_in   = (len_wide > {1'b0, COL_MAX}) ? COL_MAX : len_wide[COL_W-1:0];
    qhit     = qd_q ? b.dquote : b.squote;
    str_kind = qd_q ? KIND_DQUOTE : KIND_SQUOTE;

    mode_d   = mode_q;
    qd_d     = qd_q;
    start_d  = st;
    again    = 1'b0;
    do_str   = 1'b0;
    cont     = 1'b0;
    run_kind = KIND_NAME;
    e0_v     = 1'b0;
    e0       = '{kind: KIND_OP, start: st, len: len_ex};
    e1_v     = 1'b0;
    e1       = '{kind: KIND_OP, start: col, len: COL_W'(1)};

    unique case (mode_q)
      M_COMMENT: again = b.zero;
      M_QOPEN: begin
        if (b.squote) begin
          mode_d = M_QTWO;
        end else begin
          mode_d = M_STRING;
          do_str = 1'b1;
        end
      end
      M_STRING: do_str = 1'b1;
      M_QTWO: begin
        e0_v    = 1'b1;
        e0.kind = KIND_SQUOTE;
        if (b.squote) begin
          e0.len = len_in;
          mode_d = M_IDLE;
        end else begin
          again = 1'b1;
        end
      end
      M_DOLLAR: begin
        if (b.dollar) begin
          e0_v    = 1'b1;
          e0.kind = KIND_DOLLAR;
          e0.len  = len_in;
          mode_d  = M_IDLE;
        end else if (b.hex) begin
          mode_d = M_DHEX;
        end else begin
          e0_v    = 1'b1;
          e0.kind = KIND_DOLLAR;
          again   = 1'b1;
        end
      end
      M_DHEX, M_AHEX, M_BIN, M_NAME: begin
        case (mode_q)
          M_DHEX:  begin run_kind = KIND_DOLLAR; cont = b.hex;  end
          M_AHEX:  begin run_kind = KIND_AMP;    cont = b.hex;  end
          M_BIN:   begin run_kind = KIND_BIN;    cont = b.bin;  end
          default: begin run_kind = KIND_NAME;   cont = b.name; end
        endcase
        if (!cont) begin
          e0_v    = 1'b1;
          e0.kind = run_kind;
          again   = 1'b1;
        end
      end
      default: again = 1'b1;
    endcase

    // inside a string: close on the matching quote, or run out at line end
    if (do_str) begin
      if (qhit) begin
        e0_v    = 1'b1;
        e0.kind = str_kind;
        e0.len  = len_in;
        mode_d  = M_IDLE;
      end else if (b.zero) begin
        e0_v    = 1'b1;
        e0.kind = str_kind;
        mode_d  = M_IDLE;
        again   = 1'b1;
      end
    end

    // handle the byte as a fresh start
    if (again) begin
      mode_d = M_IDLE;
      if (b.zero) begin
        e1_v = 1'b1;
        e1   = '{kind: KIND_EOL, start: col, len: '0};
        qd_d = 1'b0;
      end else if (!b.space) begin
        start_d = col;
        if (b.semi) begin
          mode_d = M_COMMENT;
        end else if (b.op) begin
          e1_v = 1'b1;
        end else if (b.squote) begin
          qd_d   = 1'b0;
          mode_d = M_QOPEN;
        end else if (b.dquote) begin
          qd_d   = 1'b1;
          mode_d = M_STRING;
        end else if (b.dollar) begin
          mode_d = M_DOLLAR;
        end else if (b.amp) begin
          mode_d = M_AHEX;
        end else if (b.pct) begin
          mode_d = M_BIN;
        end else if (b.name) begin
          mode_d = M_NAME;
        end else begin
          e1_v    = 1'b1;
          e1.kind = KIND_STRAY;
        end
      end
    end

    res_o.two = e0_v & e1_v;
    res_o.r0  = e0_v ? e0 : e1;
    res_o.r1  = e1;
  end

  assign res_push_o = step & (e0_v | e1_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      qd_q    <= 1'b0;
      start_q <= '0;
    end else if (step) begin
      mode_q  <= mode_d;
      qd_q    <= qd_d;
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

>>> design/alt_resq.sv
// Result queue: holds entries of one or two tokens and hands them out one at a time.
// Marks the final token of each entry as last. Depends on alt_pkg.
`default_nettype none

module alt_resq import alt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire res_entry_t entry_i,
  output logic            full_o,
  output logic            empty_o,
  input  wire logic       pop_i,
  output token_t          tok_o,
  output logic            last_o
);

  res_entry_t       mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_q, rd_q;
  logic [RQ_AW:0]   cnt_q;
  logic             sub_q;
  logic             pop_ok, retire;
  res_entry_t       head;

  assign head    = mem_q[rd_q];
  assign full_o  = (cnt_q == (RQ_AW+1)'(RQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign tok_o   = sub_q ? head.r1 : head.r0;
  assign last_o  = sub_q | ~head.two;
  assign pop_ok  = pop_i & ~empty_o;
  assign retire  = pop_ok & last_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
      sub_q <= 1'b0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_ok) begin
        sub_q <= ~last_o;
      end
      if (retire) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({push_i, retire})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> design/assembler_line_tokenizer.sv
// Assembler line tokenizer: bytes in, tokens (kind, start, length) out.
// A result passes the front queue, then the scanner into the result queue, before it
// shows on the token ports, where it waits until it is taken.
// Throughput: one byte per cycle unless full_o or a full result queue stalls the input;
// a byte that closes two tokens needs two result transfers on the output side.
// Reset (rst_ni low, asynchronous): queues empty, scanner idle, column 0.
`default_nettype none

module assembler_line_tokenizer import alt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // byte side
  input  wire logic [7:0] character_i,
  input  wire logic       push_i,
  output logic            full_o,
  // token side
  output logic            empty_o,
  input  wire logic       pop_i,
  output logic [3:0]      token_kind_o,
  output logic [11:0]     token_start_o,
  output logic [11:0]     token_length_o,
  output logic            last_o
);

  fe_chan_t   fe;
  logic       fe_pop;
  logic       res_push, res_full;
  res_entry_t res_entry;
  token_t     tok;

  // Front: classify each transferred byte, stamp its column, queue it
  alt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .character_i(character_i),
    .push_i     (push_i),
    .full_o     (full_o),
    .fe_o       (fe),
    .fe_pop_i   (fe_pop)
  );

  // Back: advance the scanner one byte per cycle; stall only when the result
  // queue has no room for another entry
  alt_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fe_i      (fe),
    .fe_pop_o  (fe_pop),
    .res_push_o(res_push),
    .res_o     (res_entry),
    .res_full_i(res_full)
  );

  // Output queue: drain entries token by token, flag the last one per byte
  alt_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .entry_i(res_entry),
    .full_o (res_full),
    .empty_o(empty_o),
    .pop_i  (pop_i),
    .tok_o  (tok),
    .last_o (last_o)
  );

  assign token_kind_o   = tok.kind;
  assign token_start_o  = tok.start;
  assign token_length_o = tok.len;

endmodule

`default_nettype wire

>>> design/alt_port_checker.sv
// Port-level checks for the assembler line tokenizer, attached by bind.
// Depends on alt_pkg and the top level's ports.
`default_nettype none

module alt_port_checker import alt_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty_o,
  input wire logic        pop_i,
  input wire logic [3:0]  token_kind_o,
  input wire logic [11:0] token_start_o,
  input wire logic [11:0] token_length_o,
  input wire logic        last_o
);

  // a waiting result holds until it is transferred
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(token_kind_o) &&
    $stable(token_start_o) && $stable(token_length_o) && $stable(last_o))
    else $error("result changed while stalled");

  // the second token of a byte follows at once
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && pop_i && !last_o |=> !empty_o)
    else $error("second token of a byte missing");

  // line end is zero length and closes its byte
  a_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && token_kind_o == KIND_EOL |-> token_length_o == '0 && last_o)
    else $error("bad end-of-line token");

  // operators and stray bytes are one byte long and never first of a pair
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && (token_kind_o == KIND_OP || token_kind_o == KIND_STRAY)
    |-> token_length_o == 12'd1 && last_o)
    else $error("bad single-byte token");

endmodule

bind assembler_line_tokenizer alt_port_checker u_alt_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty_o       (empty_o),
  .pop_i         (pop_i),
  .token_kind_o  (token_kind_o),
  .token_start_o (token_start_o),
  .token_length_o(token_length_o),
  .last_o        (last_o)
);

`default_nettype wire

>>> sim/tb_assembler_line_tokenizer.sv
`timescale 1ns / 1ps
// Self-checking testbench for assembler_line_tokenizer: drives source lines byte by byte
// and checks every token against a cycle-free predictor. Depends on alt_pkg and the RTL.

module tb_assembler_line_tokenizer;
  import alt_pkg::*;

  // Scanner modes of the predictor
  typedef enum logic [3:0] {
    SC_IDLE, SC_COMMENT, SC_QOPEN, SC_QTWO, SC_STRING,
    SC_DOLLAR, SC_DHEX, SC_AHEX, SC_BIN, SC_NAME
  } scan_mode_e;

  typedef struct packed {
    logic [3:0]       kind;
    logic [COL_W-1:0] start;
    logic [COL_W-1:0] length;
    logic             last;
  } token_rec_t;

  localparam string OPERATORS = "!~+-*/\\(),={}<>";
  localparam string HEX_CHARS = "0123456789abcdefABCDEF";
  localparam string NAME_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
  localparam string STRAY_CHARS = "#@[]:?^`|";

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  character = 8'd0;
  logic        push = 1'b0;
  logic        full;
  logic        empty;
  logic        pop = 1'b0;
  logic [3:0]  tok_kind;
  logic [11:0] tok_start;
  logic [11:0] tok_length;
  logic        tok_last;

  logic [7:0]  line_bytes[$];      // bytes still to transfer, oldest first
  token_rec_t  pending_tokens[$];  // predicted tokens not yet seen on the output
  int unsigned bytes_sent = 0;
  int unsigned tokens_checked = 0;
  int unsigned mismatches = 0;
  bit          steady;

  // Predictor state
  scan_mode_e  mode = SC_IDLE;
  logic        quote_dbl = 1'b0;
  logic [11:0] tok_begin = '0;
  logic [11:0] cur_col = '0;

  assembler_line_tokenizer dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .character_i    (character),
    .push_i         (push),
    .full_o         (full),
    .empty_o        (empty),
    .pop_i          (pop),
    .token_kind_o   (tok_kind),
    .token_start_o  (tok_start),
    .token_length_o (tok_length),
    .last_o         (tok_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // No idling on either side while this window of bytes goes through
  assign steady = (bytes_sent >= 300) && (bytes_sent < 500);

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [11:0] clamp_col(int unsigned x);
    return (x > COL_MAX) ? COL_MAX : x[11:0];
  endfunction

  function automatic bit is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  // Letters, digits, underscore and dot all extend a name or number
  function automatic bit is_name(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
           (c >= "A" && c <= "Z") || c == "_" || c == ".";
  endfunction

  function automatic void add_token(logic [3:0] kind, logic [11:0] start, int unsigned len);
    token_rec_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = clamp_col(len);
    t.last   = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  // Byte inside a string; returns 1 when the byte must also start a new token
  function automatic bit string_byte(logic [7:0] c, logic [11:0] col);
    logic [3:0] kind;
    logic [7:0] quote;
    kind  = quote_dbl ? KIND_DQUOTE : KIND_SQUOTE;
    quote = quote_dbl ? 8'h22 : 8'h27;
    if (c == quote) begin
      add_token(kind, tok_begin, int'(col) + 1 - int'(tok_begin));
      mode = SC_IDLE;
      return 1'b0;
    end
    if (c == 8'd0) begin
      // unterminated: the string runs to the end of the line
      add_token(kind, tok_begin, int'(col) - int'(tok_begin));
      mode = SC_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the predictor by one transferred byte and queue the tokens it causes
  function automatic void predict_byte(logic [7:0] c);
    logic [11:0] col;
    bit          reenter;
    bit          more;
    logic [3:0]  kind;
    int unsigned n_before;
    col      = cur_col;
    reenter  = 1'b0;
    more     = 1'b0;
    kind     = KIND_NAME;
    n_before = pending_tokens.size();
    if (tok_begin > col) tok_begin = col;

    case (mode)
      SC_COMMENT: reenter = (c == 8'd0);
      SC_QOPEN: begin
        if (c == 8'h27) mode = SC_QTWO;
        else begin
          mode    = SC_STRING;
          reenter = string_byte(c, col);
        end
      end
      SC_QTWO: begin
        // three quotes make one token; two quotes then anything else close at two
        if (c == 8'h27) begin
          add_token(KIND_SQUOTE, tok_begin, int'(col) + 1 - int'(tok_begin));
          mode = SC_IDLE;
        end else begin
          add_token(KIND_SQUOTE, tok_begin, int'(col) - int'(tok_begin));
          reenter = 1'b1;
        end
      end
      SC_STRING: reenter = string_byte(c, col);
      SC_DOLLAR: begin
        if (c == "$") begin
          add_token(KIND_DOLLAR, tok_begin, int'(col) + 1 - int'(tok_begin));
          mode = SC_IDLE;
        end else if (is_hex(c)) begin
          mode = SC_DHEX;
        end else begin
          add_token(KIND_DOLLAR, tok_begin, int'(col) - int'(tok_begin));
          reenter = 1'b1;
        end
      end
      SC_DHEX, SC_AHEX, SC_BIN, SC_NAME: begin
        case (mode)
          SC_DHEX: begin kind = KIND_DOLLAR; more = is_hex(c); end
          SC_AHEX: begin kind = KIND_AMP;    more = is_hex(c); end
          SC_BIN:  begin kind = KIND_BIN;    more = (c == "0" || c == "1"); end
          default: begin kind = KIND_NAME;   more = is_name(c); end
        endcase
        if (!more) begin
          add_token(kind, tok_begin, int'(col) - int'(tok_begin));
          reenter = 1'b1;
        end
      end
      default: reenter = 1'b1;
    endcase

    // Handle the byte as the start of something new
    if (reenter) begin
      mode = SC_IDLE;
      if (c == 8'd0) begin
        add_token(KIND_EOL, col, 0);
        quote_dbl = 1'b0;
      end else if (c > 8'd32) begin
        tok_begin = col;
        case (c)
          ";": mode = SC_COMMENT;
          "!", "~", "+", "-", "*", "/", "\\", "(", ")", ",", "=", "{", "}", "<", ">":
            add_token(KIND_OP, col, 1);
          8'h27: begin quote_dbl = 1'b0; mode = SC_QOPEN; end
          8'h22: begin quote_dbl = 1'b1; mode = SC_STRING; end
          "$": mode = SC_DOLLAR;
          "&": mode = SC_AHEX;
          "%": mode = SC_BIN;
          default: begin
            if (is_name(c)) mode = SC_NAME;
            else add_token(KIND_STRAY, col, 1);
          end
        endcase
      end
    end

    cur_col = (c == 8'd0) ? 12'd0 : clamp_col(int'(col) + 1);
    if (pending_tokens.size() > n_before) pending_tokens[pending_tokens.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Byte driver: present the head of line_bytes, hold it until transferred
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    bit go;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_byte(character);
        void'(line_bytes.pop_front());
        bytes_sent++;
      end
      // hold a stalled byte; otherwise idle with a chance of 36 in a hundred
      go = (line_bytes.size() > 0) &&
           ((push && full) || steady || ($urandom_range(99) >= 36));
      push <= go;
      if (go) character <= line_bytes[0];
    end
  end

  // ---------------------------------------------------------------------------
  // Token monitor: compare each transferred token with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : token_monitor
    token_rec_t want;
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        tokens_checked++;
        if (pending_tokens.size() == 0) begin
          $error("unpredicted token: kind %0d start %0d length %0d last %0d",
                 tok_kind, tok_start, tok_length, tok_last);
          mismatches++;
        end else begin
          want = pending_tokens.pop_front();
          if (tok_kind !== want.kind) begin
            $error("token_kind: expected %0d, got %0d", want.kind, tok_kind);
            mismatches++;
          end
          if (tok_start !== want.start) begin
            $error("token_start: expected %0d, got %0d", want.start, tok_start);
            mismatches++;
          end
          if (tok_length !== want.length) begin
            $error("token_length: expected %0d, got %0d", want.length, tok_length);
            mismatches++;
          end
          if (tok_last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, tok_last);
            mismatches++;
          end
        end
      end
      pop <= steady || ($urandom_range(99) >= 36);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick(string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  // Random non-zero byte that is not the given quote
  function automatic logic [7:0] string_fill(logic [7:0] quote);
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1)); while (b == quote);
    return b;
  endfunction

  // One well-formed token with random content
  function automatic void put_token();
    int unsigned n;
    case ($urandom_range(7))
      0: line_bytes.push_back(pick(OPERATORS));
      1: begin
        case ($urandom_range(3))
          0: put_str("''");
          1: put_str("'''");
          default: begin
            line_bytes.push_back(8'h27);
            n = $urandom_range(5, 1);
            repeat (n) line_bytes.push_back(string_fill(8'h27));
            line_bytes.push_back(8'h27);
          end
        endcase
      end
      2: begin
        line_bytes.push_back(8'h22);
        n = $urandom_range(6);
        repeat (n) line_bytes.push_back(string_fill(8'h22));
        line_bytes.push_back(8'h22);
      end
      3: begin
        line_bytes.push_back("$");
        case ($urandom_range(2))
          0: ;
          1: line_bytes.push_back("$");
          default: repeat ($urandom_range(4, 1)) line_bytes.push_back(pick(HEX_CHARS));
        endcase
      end
      4: begin
        line_bytes.push_back("&");
        repeat ($urandom_range(4)) line_bytes.push_back(pick(HEX_CHARS));
      end
      5: begin
        line_bytes.push_back("%");
        repeat ($urandom_range(6)) line_bytes.push_back($urandom_range(1) ? "1" : "0");
      end
      6: repeat ($urandom_range(8, 1)) line_bytes.push_back(pick(NAME_CHARS));
      default: begin
        if ($urandom_range(1)) line_bytes.push_back(pick(STRAY_CHARS));
        else line_bytes.push_back(8'($urandom_range(255, 127)));
      end
    endcase
  endfunction

  // One line ending in a zero byte: mostly well-formed, sometimes pure noise
  function automatic void put_line();
    int unsigned n;
    if ($urandom_range(99) < 85) begin
      n = $urandom_range(8, 1);
      repeat (n) begin
        repeat ($urandom_range(2)) line_bytes.push_back(8'($urandom_range(32, 1)));
        put_token();
      end
      case ($urandom_range(9))
        0, 1: begin
          line_bytes.push_back(";");
          repeat ($urandom_range(8)) line_bytes.push_back(8'($urandom_range(255, 1)));
        end
        2: begin
          // leave a string open until the end of the line
          line_bytes.push_back($urandom_range(1) ? 8'h22 : 8'h27);
          repeat ($urandom_range(4)) line_bytes.push_back(pick(NAME_CHARS));
        end
        default: ;
      endcase
    end else begin
      repeat ($urandom_range(20, 1)) line_bytes.push_back(8'($urandom_range(255)));
    end
    line_bytes.push_back(8'd0);
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed line, random lines, drain
  // ---------------------------------------------------------------------------
  initial begin
    // Directed: names with dots, two and three quotes, lone and double dollar,
    // hex/amp/binary prefixes, a closed string, a high stray byte, an open string
    put_str("a.''+'''$ $$$Af&c%10\"q\"");
    line_bytes.push_back(8'hFF);
    put_str("'x");
    line_bytes.push_back(8'd0);

    while (line_bytes.size() < 780) put_line();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (line_bytes.size() != 0) @(posedge clk);
    while (pending_tokens.size() != 0) @(posedge clk);
    // allow the pipeline to show any stray token
    repeat (20) @(posedge clk);

    $display("Run summary: %0d bytes transferred, %0d tokens checked, %0d mismatches;",
             bytes_sent, tokens_checked, mismatches);
    $display("lines covered every token kind, open strings, comments and stalls on both sides.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
design/alt_pkg.sv
design/alt_front.sv
design/alt_back.sv
design/alt_resq.sv
design/assembler_line_tokenizer.sv
design/alt_port_checker.sv
sim/tb_assembler_line_tokenizer.sv
